### rtl/core/thlkr_pkg.sv
package thlkr_pkg;

	localparam int unsigned CodeW  = 7;
	localparam int unsigned KindW  = 2;
	localparam int unsigned ModW   = 4;
	localparam int unsigned TimeW  = 48;
	localparam int unsigned ThrW   = 32;
	localparam int unsigned PaddrW = 4;
	localparam int unsigned PdataW = 32;

	localparam logic [ThrW-1:0]  HoldThresholdRst = 32'd200000;
	localparam logic [CodeW-1:0] LayerKeyCodeRst  = 7'd10;
	localparam logic [CodeW-1:0] TapKeyCodeRst    = 7'd53;

	// Register byte addresses
	localparam logic [PaddrW-1:0] AddrHoldThreshold = 4'd0;
	localparam logic [PaddrW-1:0] AddrLayerKeyCode  = 4'd4;
	localparam logic [PaddrW-1:0] AddrTapKeyCode    = 4'd8;

	typedef enum logic [KindW-1:0] {
		EV_DOWN  = 2'd0,
		EV_UP    = 2'd1,
		EV_FLAGS = 2'd2
	} event_kind_t;

	localparam logic [ModW-1:0] ModControl = 4'b0001;
	localparam logic [ModW-1:0] ModShift   = 4'b0010;
	localparam logic [ModW-1:0] ModCommand = 4'b0100;
	localparam logic [ModW-1:0] ModOption  = 4'b1000;

	typedef struct packed {
		logic [CodeW-1:0] key_code;
		logic [KindW-1:0] event_kind;
		logic [ModW-1:0]  modifier_bits;
		logic [TimeW-1:0] time_now;
	} item_t;

	typedef struct packed {
		logic [CodeW-1:0] out_key_code;
		logic [KindW-1:0] out_kind;
		logic [ModW-1:0]  out_modifiers;
		logic             last_of_run;
	} result_t;

	typedef struct packed {
		logic             layer_held;
		logic [TimeW-1:0] press_stamp;
		logic             layer_engaged;
		logic [ModW-1:0]  sticky_modifiers;
	} state_t;

	typedef struct packed {
		logic [ThrW-1:0]  hold_limit;
		logic [CodeW-1:0] layer_key_code;
		logic [CodeW-1:0] tap_key_code;
	} cfg_t;

	typedef struct packed {
		logic [1:0] num_results;
		result_t    first;
		result_t    second;
		state_t     next_state;
	} decision_t;

	// Navigation remap while the layer is engaged; bit CodeW marks a hit.
	function automatic logic [CodeW:0] nav_map(input logic [CodeW-1:0] code);
		logic [CodeW:0] res;
		case (code)
			7'd4:    res = {1'b1, 7'd123};
			7'd38:   res = {1'b1, 7'd125};
			7'd40:   res = {1'b1, 7'd126};
			7'd37:   res = {1'b1, 7'd124};
			7'd34:   res = {1'b1, 7'd116};
			7'd31:   res = {1'b1, 7'd121};
			7'd43:   res = {1'b1, 7'd115};
			7'd47:   res = {1'b1, 7'd119};
			default: res = '0;
		endcase
		return res;
	endfunction

	function automatic logic [ModW-1:0] sticky_bit_of(input logic [CodeW-1:0] code);
		logic [ModW-1:0] res;
		res = '0;
		if (code inside {7'd59, 7'd62}) begin
			res = ModControl;
		end else if (code inside {7'd60, 7'd56}) begin
			res = ModShift;
		end else if (code inside {7'd55, 7'd54}) begin
			res = ModCommand;
		end else if (code inside {7'd58, 7'd61}) begin
			res = ModOption;
		end
		return res;
	endfunction

endpackage

### rtl/core/thlkr_if.sv
interface thlkr_in_if;
	logic                          valid;
	logic                          ready;
	logic [thlkr_pkg::CodeW-1:0]   key_code;
	logic [thlkr_pkg::KindW-1:0]   event_kind;
	logic [thlkr_pkg::ModW-1:0]    modifier_bits;
	logic                          fresh_press;
	logic [thlkr_pkg::TimeW-1:0]   time_now;

	modport source (output valid, key_code, event_kind, modifier_bits, fresh_press,
		time_now, input ready);
	modport sink (input valid, key_code, event_kind, modifier_bits, fresh_press,
		time_now, output ready);
endinterface

interface thlkr_out_if;
	logic                          valid;
	logic                          ready;
	logic [thlkr_pkg::CodeW-1:0]   out_key_code;
	logic [thlkr_pkg::KindW-1:0]   out_kind;
	logic [thlkr_pkg::ModW-1:0]    out_modifiers;
	logic                          last_of_run;

	modport source (output valid, out_key_code, out_kind, out_modifiers, last_of_run,
		input ready);
	modport sink (input valid, out_key_code, out_kind, out_modifiers, last_of_run,
		output ready);
endinterface

### rtl/core/thlkr_decide.sv
module thlkr_decide (
	input  thlkr_pkg::item_t     item,
	input  thlkr_pkg::state_t    state,
	input  thlkr_pkg::cfg_t      cfg,
	output thlkr_pkg::decision_t dec
);

	logic [thlkr_pkg::TimeW-1:0] held_for;
	logic                        held_long;
	logic                        is_layer;
	logic [thlkr_pkg::CodeW:0]   nav;
	logic                        pass;
	logic [thlkr_pkg::ModW-1:0]  sticky_next;

	assign held_for  = item.time_now - state.press_stamp;
	assign held_long = held_for >= {{(thlkr_pkg::TimeW-thlkr_pkg::ThrW){1'b0}},
		cfg.hold_limit};
	assign is_layer  = item.key_code == cfg.layer_key_code;
	assign nav       = thlkr_pkg::nav_map(item.key_code);
	assign sticky_next = state.sticky_modifiers ^ thlkr_pkg::sticky_bit_of(item.key_code);

	always_comb begin
		dec             = '0;
		dec.next_state  = state;
		pass            = 1'b0;
		case (item.event_kind)
			thlkr_pkg::EV_DOWN, thlkr_pkg::EV_UP, thlkr_pkg::EV_FLAGS: begin
				if (is_layer) begin
					if (item.event_kind == thlkr_pkg::EV_DOWN) begin
						if (!state.layer_held) begin
							dec.next_state.layer_held    = 1'b1;
							dec.next_state.press_stamp   = item.time_now;
							dec.next_state.layer_engaged = 1'b0;
						end
					end else if (item.event_kind == thlkr_pkg::EV_UP && state.layer_held) begin
						dec.next_state.layer_held    = 1'b0;
						dec.next_state.layer_engaged = 1'b0;
						// A tap emits the tap key down and up with no modifiers.
						if (!state.layer_engaged && !held_long) begin
							dec.num_results            = 2'd2;
							dec.first.out_key_code     = cfg.tap_key_code;
							dec.first.out_kind         = thlkr_pkg::EV_DOWN;
							dec.second.out_key_code    = cfg.tap_key_code;
							dec.second.out_kind        = thlkr_pkg::EV_UP;
							dec.second.last_of_run     = 1'b1;
						end
					end
				end else begin
					pass = 1'b1;
					if (state.layer_held && item.event_kind == thlkr_pkg::EV_DOWN) begin
						if (held_long) begin
							dec.next_state.layer_engaged = 1'b1;
							pass = !nav[thlkr_pkg::CodeW];
						end
					end else if (state.layer_held && item.event_kind == thlkr_pkg::EV_UP &&
						state.layer_engaged) begin
						pass = !nav[thlkr_pkg::CodeW];
					end
					dec.num_results          = 2'd1;
					dec.first.last_of_run    = 1'b1;
					dec.first.out_kind       = item.event_kind;
					if (pass) begin
						dec.next_state.sticky_modifiers = sticky_next;
						dec.first.out_key_code  = item.key_code;
						dec.first.out_modifiers = item.modifier_bits | sticky_next;
					end else begin
						// Remapped keys keep the incoming modifiers only.
						dec.first.out_key_code  = nav[thlkr_pkg::CodeW-1:0];
						dec.first.out_modifiers = item.modifier_bits;
					end
				end
			end
			default: begin
				dec.num_results = 2'd0;
			end
		endcase
	end

endmodule

### rtl/core/tap_hold_layer_key_remapper_unit.sv
// Tap-hold layer key remapper. Keyboard events enter on key_in and the resulting
// events leave on key_out, each transaction on a valid/ready handshake. An event is
// registered on entry and decided in one pass against the layer and sticky-modifier
// state; its first result is then loaded into the output register once that
// register is free, and leaves the unit from there.
// Events that give zero or one result are taken at one per cycle while key_out
// accepts every result; a tap of the layer key gives two results, which leave one
// after the other through the single output register. The hold threshold, the layer
// key code and the tap key code are written through the APB port (byte addresses
// 0, 4 and 8) and should only be changed while no events are in flight.
module tap_hold_layer_key_remapper_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [thlkr_pkg::PaddrW-1:0]       paddr,
	input  logic [thlkr_pkg::PdataW-1:0]       pwdata,
	output logic [thlkr_pkg::PdataW-1:0]       prdata,
	output logic                               pready,
	thlkr_in_if.sink                           key_in,
	thlkr_out_if.source                        key_out
);

	thlkr_pkg::cfg_t      cfg_q;
	thlkr_pkg::state_t    state_q;
	thlkr_pkg::item_t     item_s1;
	logic                 valid_s1;
	thlkr_pkg::decision_t dec;
	thlkr_pkg::result_t   res_s2;
	logic                 valid_s2;
	thlkr_pkg::result_t   second_q;
	logic                 second_pend_q;
	logic                 out_free;
	logic                 consume;
	logic                 out_taken;
	logic                 cfg_wr;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_limit     <= thlkr_pkg::HoldThresholdRst;
			cfg_q.layer_key_code <= thlkr_pkg::LayerKeyCodeRst;
			cfg_q.tap_key_code   <= thlkr_pkg::TapKeyCodeRst;
		end else if (cfg_wr) begin
			case (paddr)
				thlkr_pkg::AddrHoldThreshold: cfg_q.hold_limit <= pwdata;
				thlkr_pkg::AddrLayerKeyCode:
					cfg_q.layer_key_code <= pwdata[thlkr_pkg::CodeW-1:0];
				thlkr_pkg::AddrTapKeyCode:
					cfg_q.tap_key_code <= pwdata[thlkr_pkg::CodeW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			thlkr_pkg::AddrHoldThreshold: prdata = cfg_q.hold_limit;
			thlkr_pkg::AddrLayerKeyCode:
				prdata = {{(thlkr_pkg::PdataW-thlkr_pkg::CodeW){1'b0}}, cfg_q.layer_key_code};
			thlkr_pkg::AddrTapKeyCode:
				prdata = {{(thlkr_pkg::PdataW-thlkr_pkg::CodeW){1'b0}}, cfg_q.tap_key_code};
			default: prdata = '0;
		endcase
	end

	// Handshake control. The output register is free when empty, or when its
	// transaction completes this cycle and no second tap result is waiting.
	assign out_taken    = valid_s2 & key_out.ready;
	assign out_free     = !valid_s2 || (key_out.ready && !second_pend_q);
	assign consume      = valid_s1 & out_free;
	assign key_in.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key_in.ready) begin
			valid_s1 <= key_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key_in.valid && key_in.ready) begin
			item_s1.key_code      <= key_in.key_code;
			item_s1.event_kind    <= key_in.event_kind;
			item_s1.modifier_bits <= key_in.modifier_bits;
			item_s1.time_now      <= key_in.time_now;
		end
	end

	thlkr_decide u_decide (
		.item  (item_s1),
		.state (state_q),
		.cfg   (cfg_q),
		.dec   (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (consume) begin
			state_q <= dec.next_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			second_pend_q <= 1'b0;
		end else if (consume && dec.num_results != 2'd0) begin
			valid_s2      <= 1'b1;
			second_pend_q <= dec.num_results == 2'd2;
		end else if (out_taken) begin
			valid_s2      <= second_pend_q;
			second_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && dec.num_results != 2'd0) begin
			res_s2   <= dec.first;
			second_q <= dec.second;
		end else if (out_taken && second_pend_q) begin
			res_s2 <= second_q;
		end
	end

	assign key_out.valid         = valid_s2;
	assign key_out.out_key_code  = res_s2.out_key_code;
	assign key_out.out_kind      = res_s2.out_kind;
	assign key_out.out_modifiers = res_s2.out_modifiers;
	assign key_out.last_of_run   = res_s2.last_of_run;

endmodule
